>>> rtl/bhm_pkg.sv
`default_nettype none

package bhm_pkg;

    // Fixed field widths of the two channels
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 31;
    localparam int RVAL_W   = 32;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_GET    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    // Read value returned for every result but that of a GET that found its key
    localparam logic [RVAL_W-1:0] NOT_A_VALUE = {RVAL_W{1'b1}};

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;  // clear one row of valid bits
        logic capture;     // input transfer: register the item, read its bucket row
        logic commit;      // write the row back and load the output register
    } bhm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;  // the clearing pass is on its last row
        logic out_full;    // the output register holds a result not yet taken
    } bhm_stat_t;

endpackage

`default_nettype wire

>>> rtl/bhm_ctrl.sv
`default_nettype none

module bhm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              m_ready,
    input  wire bhm_pkg::bhm_stat_t stat,
    output bhm_pkg::bhm_cmd_t      cmd
);
    import bhm_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd.clear_step = 1'b0;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The result may only be loaded once the output register is free.
                if (!stat.out_full || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/bhm_dpath.sv
`default_nettype none

module bhm_dpath #(
    parameter int KEYS_PER_BUCKET = 128,
    parameter int BUCKETS         = 8192,
    parameter int WAYS            = 8,
    parameter int KEY_BITS        = 20
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire bhm_pkg::bhm_cmd_t                cmd,
    output bhm_pkg::bhm_stat_t                    stat,
    input  wire logic [bhm_pkg::OPCODE_W-1:0]     s_opcode,
    input  wire logic [KEY_BITS-1:0]              s_key,
    input  wire logic [bhm_pkg::VALUE_W-1:0]      s_value,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic signed [bhm_pkg::RVAL_W-1:0]     m_read_value,
    output logic [bhm_pkg::STATUS_W-1:0]          m_status
);
    import bhm_pkg::*;

    // KEYS_PER_BUCKET and BUCKETS must be powers of two, which the block does not check: shift and mask.
    localparam int KPB_SHIFT = $clog2(KEYS_PER_BUCKET);
    localparam int BKT_W     = $clog2(BUCKETS);
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_W   = KEY_BITS + VALUE_W;
    localparam int ROW_W     = WAYS * ENTRY_W;

    // Bucket rows: each way holds {key, value}; valid bits in a memory of their own
    logic [ROW_W-1:0] entry_mem [BUCKETS];
    logic [WAYS-1:0]  valid_mem [BUCKETS];

    logic [KEY_BITS+BKT_W-1:0] key_ext;
    logic [KEY_BITS+BKT_W-1:0] key_shifted;
    logic [BKT_W-1:0]          bucket;

    logic [OPCODE_W-1:0] op_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [BKT_W-1:0]    bucket_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [WAYS-1:0]     vld_reg;
    logic [BKT_W-1:0]    clr_addr_reg;

    logic [WAYS-1:0]     match;
    logic                hit;
    logic [WAY_W-1:0]    hit_idx;
    logic                free_any;
    logic [WAY_W-1:0]    free_idx;
    logic [ROW_W-1:0]    row_new;
    logic [WAYS-1:0]     vld_new;
    logic                row_wr;
    logic [RVAL_W-1:0]   rval_new;
    logic [STATUS_W-1:0] status_new;

    logic                m_valid_reg;
    logic [RVAL_W-1:0]   rval_reg;
    logic [STATUS_W-1:0] status_reg;

    // Bucket index of the incoming key
    assign key_ext     = {{BKT_W{1'b0}}, s_key};
    assign key_shifted = key_ext >> KPB_SHIFT;
    assign bucket      = key_shifted[BKT_W-1:0];

    // Clearing pass over the valid memory after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign stat.clear_last = (clr_addr_reg == BKT_W'(BUCKETS - 1));
    assign stat.out_full   = m_valid_reg;

    // Item registers and registered row read on an input transfer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= s_opcode;
            key_reg    <= s_key;
            value_reg  <= s_value;
            bucket_reg <= bucket;
            row_reg    <= entry_mem[bucket];
            vld_reg    <= valid_mem[bucket];
        end
    end

    // Compare all ways with the key; find the matching and the lowest free way
    always_comb begin
        match    = '0;
        hit_idx  = '0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w] = vld_reg[w] && (row_reg[w*ENTRY_W+VALUE_W +: KEY_BITS] == key_reg);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_idx = WAY_W'(w);
            end
            if (!vld_reg[w]) begin
                free_idx = WAY_W'(w);
            end
        end
        hit      = |match;
        free_any = ~&vld_reg;
    end

    // Modified row, result and status
    always_comb begin
        row_new    = row_reg;
        vld_new    = vld_reg;
        row_wr     = 1'b0;
        rval_new   = NOT_A_VALUE;
        status_new = STATUS_OK;
        case (op_reg)
            OP_PUT: begin
                if (hit) begin
                    row_new[hit_idx*ENTRY_W +: VALUE_W] = value_reg;
                    row_wr = 1'b1;
                end else if (free_any) begin
                    row_new[free_idx*ENTRY_W +: ENTRY_W] = {key_reg, value_reg};
                    vld_new[free_idx] = 1'b1;
                    row_wr = 1'b1;
                end else begin
                    status_new = STATUS_FULL;
                end
            end
            OP_GET: begin
                if (hit) begin
                    rval_new = {1'b0, row_reg[hit_idx*ENTRY_W +: VALUE_W]};
                end else begin
                    status_new = STATUS_NOT_FOUND;
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    vld_new[hit_idx] = 1'b0;
                end else begin
                    status_new = STATUS_NOT_FOUND;
                end
            end
            default: begin
                status_new = STATUS_OK;
            end
        endcase
    end

    // Write-back of the row
    always_ff @(posedge aclk) begin
        if (cmd.commit && row_wr) begin
            entry_mem[bucket_reg] <= row_new;
        end
    end

    // Valid memory: cleared row by row after reset, written back on commit
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            valid_mem[clr_addr_reg] <= '0;
        end else if (cmd.commit) begin
            valid_mem[bucket_reg] <= vld_new;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            rval_reg   <= rval_new;
            status_reg <= status_new;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = signed'(rval_reg);
    assign m_status     = status_reg;

endmodule

`default_nettype wire

>>> rtl/bucketed_hash_map.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_opcode, s_key, s_value
// m_       out        m_valid / m_ready  m_read_value, m_status
//
// Each operation reads the bucket row into a register in the transfer cycle;
// the row is then compared, modified and written back on commit.
// After reset a clearing pass over all BUCKETS rows (8192 by default) zeroes the
// valid bits; s_ready stays low throughout it.
// A result waits in the output register; the next item is still accepted,
// and its write-back waits until the previous result has been taken.
`default_nettype none

module bucketed_hash_map #(
    parameter int KEYS_PER_BUCKET = 128,
    parameter int BUCKETS         = 8192,
    parameter int WAYS            = 8,
    parameter int KEY_BITS        = 20
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [bhm_pkg::OPCODE_W-1:0] s_opcode,
    input  wire logic [KEY_BITS-1:0]          s_key,
    input  wire logic [bhm_pkg::VALUE_W-1:0]  s_value,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [bhm_pkg::RVAL_W-1:0] m_read_value,
    output logic [bhm_pkg::STATUS_W-1:0]      m_status
);
    import bhm_pkg::*;

    bhm_cmd_t  cmd;
    bhm_stat_t stat;

    // Sequencer
    bhm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Bucket memories, way compare and output register
    bhm_dpath #(
        .KEYS_PER_BUCKET (KEYS_PER_BUCKET),
        .BUCKETS         (BUCKETS),
        .WAYS            (WAYS),
        .KEY_BITS        (KEY_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_opcode     (s_opcode),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status)
    );

endmodule

`default_nettype wire

>>> rtl/bhm_checker.sv
`default_nettype none

module bhm_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [bhm_pkg::RVAL_W-1:0]   m_read_value,
    input wire logic [bhm_pkg::STATUS_W-1:0] m_status
);
    import bhm_pkg::*;

    // Reset empties the output register and starts the clearing pass.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("output valid or input ready just after reset");

    // One operation at a time: no transfer in the cycle after a transfer.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready in the cycle after a transfer");

    // A value is only returned with an ok status.
    a_value_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_read_value != NOT_A_VALUE) |-> m_status == STATUS_OK)
        else $error("read value returned with an error status");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value) && $stable(m_status))
        else $error("stalled result changed");

endmodule

bind bucketed_hash_map bhm_checker u_bhm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_value (m_read_value),
    .m_status     (m_status)
);

`default_nettype wire
